// ----- sv/assert_macros.svh -----
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- sv/owrs_pkg.sv -----
// shared types and constants of the 1-wire rom search engine
package owrs_pkg;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_BIT    = 2'd1,
      CMD_RESET  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_SEND   = 3'd0,
      ACT_WRITE  = 3'd1,
      ACT_FOUND  = 3'd2,
      ACT_NONE   = 3'd3,
      ACT_REJECT = 3'd4
   } action_type;

   localparam logic [7:0] SEARCH_CMD_RESET = 8'd240;
   localparam logic [6:0] LAST_BIT         = 7'd64;
   localparam logic [6:0] FAMILY_BITS      = 7'd8;
   localparam logic [6:0] FIRST_BIT        = 7'd1;

endpackage

// ----- sv/onewire_rom_search_top.sv -----
// top level of the 1-wire rom search engine
//
// usage
//   req channel (valid/ready) carries one word per bus event: start after a
//   bus reset (with the presence answer), one id/complement bit pair, or a
//   reset of the search marks
//   rsp channel (valid/ready) returns exactly one word per request word: what
//   to do next on the bus (send command, write direction bit, device found,
//   search ended, rejected), the direction bit, the command byte, the rom id
//   built so far, the family discrepancy and the last-device flag
//   csr_wr_en/csr_wr_data write the search command byte (240 after reset); the
//   user writes it only while the engine is idle, the block does not enforce it
// timing
//   rsp_valid rises in the cycle after req acceptance; one word per cycle is
//   sustained while results are taken, set by the single result register
//   when the receiver stalls the result register holds and req_ready drops
//   until the result is taken; a word is accepted in the same cycle the
//   waiting result leaves
// reset
//   synchronous, active high: no search active, marks and rom id cleared,
//   bit position 1, no result pending
module onewire_rom_search_top
   import owrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic        req_presence,
   input  logic        req_id_bit,
   input  logic        req_complement_bit,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic        rsp_direction,
   output logic [7:0]  rsp_command_byte,
   output logic [63:0] rsp_rom_id,
   output logic [3:0]  rsp_family_discrepancy,
   output logic        rsp_last_device,
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   // search state
   logic [7:0]  search_cmd_ff;
   logic [63:0] rom_bits_ff, rom_bits_in;
   logic [6:0]  last_disc_ff, last_disc_in;
   logic [3:0]  family_mark_ff, family_mark_in;
   logic        last_dev_ff, last_dev_in;
   logic [6:0]  bit_pos_ff, bit_pos_in;
   logic [6:0]  pass_zero_ff, pass_zero_in;
   logic        searching_ff, searching_in;

   // result register
   logic        rsp_valid_ff;
   action_type  action_ff, action_in;
   logic        dir_ff, dir_in;
   logic [7:0]  cbyte_ff, cbyte_in;

   logic        accept;
   logic [5:0]  bit_idx;
   cmd_type     cmd;

   // a new word enters whenever the result slot is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_cmd);

   // bit position runs 1..64, rom id bit is position minus one
   assign bit_idx = bit_pos_ff[5:0] - 6'd1;

   always_comb begin
      rom_bits_in    = rom_bits_ff;
      last_disc_in   = last_disc_ff;
      family_mark_in = family_mark_ff;
      last_dev_in    = last_dev_ff;
      bit_pos_in     = bit_pos_ff;
      pass_zero_in   = pass_zero_ff;
      searching_in   = searching_ff;
      action_in      = ACT_REJECT;
      dir_in         = 1'b0;
      cbyte_in       = 8'd0;

      case (cmd)
         CMD_START: begin
            if (last_dev_ff || !req_presence) begin
               // nobody answered or all devices already found
               last_disc_in   = 7'd0;
               last_dev_in    = 1'b0;
               family_mark_in = 4'd0;
               searching_in   = 1'b0;
               action_in      = ACT_NONE;
            end else begin
               searching_in = 1'b1;
               bit_pos_in   = FIRST_BIT;
               pass_zero_in = 7'd0;
               action_in    = ACT_SEND;
               cbyte_in     = search_cmd_ff;
            end
         end
         CMD_RESET: begin
            last_disc_in   = 7'd0;
            last_dev_in    = 1'b0;
            family_mark_in = 4'd0;
            searching_in   = 1'b0;
            action_in      = ACT_REJECT;
         end
         CMD_BIT: begin
            if (searching_ff) begin
               if (req_id_bit && req_complement_bit) begin
                  // no device left on the bus, abort the pass
                  last_disc_in   = 7'd0;
                  last_dev_in    = 1'b0;
                  family_mark_in = 4'd0;
                  searching_in   = 1'b0;
                  action_in      = ACT_NONE;
               end else begin
                  if (req_id_bit != req_complement_bit) begin
                     // all devices agree on this bit
                     dir_in = req_id_bit;
                  end else begin
                     // discrepancy: follow the previous path, then take one
                     if (bit_pos_ff < last_disc_ff) begin
                        dir_in = rom_bits_ff[bit_idx];
                     end else begin
                        dir_in = (bit_pos_ff == last_disc_ff);
                     end
                     if (!dir_in) begin
                        pass_zero_in = bit_pos_ff;
                        if (bit_pos_ff <= FAMILY_BITS) begin
                           family_mark_in = bit_pos_ff[3:0];
                        end
                     end
                  end
                  rom_bits_in[bit_idx] = dir_in;

                  if (bit_pos_ff >= LAST_BIT) begin
                     // end of pass
                     searching_in = 1'b0;
                     bit_pos_in   = FIRST_BIT;
                     last_disc_in = pass_zero_in;
                     if (pass_zero_in == 7'd0) begin
                        last_dev_in = 1'b1;
                     end
                     if (rom_bits_in[7:0] == 8'd0) begin
                        // zero family code is not a valid device
                        last_disc_in   = 7'd0;
                        last_dev_in    = 1'b0;
                        family_mark_in = 4'd0;
                        action_in      = ACT_NONE;
                     end else begin
                        action_in = ACT_FOUND;
                     end
                  end else begin
                     bit_pos_in = bit_pos_ff + 7'd1;
                     action_in  = ACT_WRITE;
                  end
               end
            end
         end
         default: begin
            action_in = ACT_REJECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_cmd_ff  <= SEARCH_CMD_RESET;
         rom_bits_ff    <= 64'd0;
         last_disc_ff   <= 7'd0;
         family_mark_ff <= 4'd0;
         last_dev_ff    <= 1'b0;
         bit_pos_ff     <= FIRST_BIT;
         pass_zero_ff   <= 7'd0;
         searching_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            search_cmd_ff <= csr_wr_data;
         end
         if (accept) begin
            rom_bits_ff    <= rom_bits_in;
            last_disc_ff   <= last_disc_in;
            family_mark_ff <= family_mark_in;
            last_dev_ff    <= last_dev_in;
            bit_pos_ff     <= bit_pos_in;
            pass_zero_ff   <= pass_zero_in;
            searching_ff   <= searching_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded only with an accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= action_in;
         dir_ff    <= dir_in;
         cbyte_ff  <= cbyte_in;
      end
   end

   // state only moves on acceptance, which also reloads the result, so the
   // state registers always match the pending result
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_action             = action_ff;
   assign rsp_direction          = dir_ff;
   assign rsp_command_byte       = cbyte_ff;
   assign rsp_rom_id             = rom_bits_ff;
   assign rsp_family_discrepancy = family_mark_ff;
   assign rsp_last_device        = last_dev_ff;

endmodule

// ----- sv/owrs_checker.sv -----
// port-level checker of the 1-wire rom search engine and its bind
`include "assert_macros.svh"

module owrs_checker
   import owrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_action,
   input logic        rsp_direction,
   input logic [7:0]  rsp_command_byte,
   input logic [3:0]  rsp_family_discrepancy
);

   // a stalled result keeps its word
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) && $stable(rsp_direction), "stalled result changed")

   // every accepted word gives a result in the next cycle
   `ASSERT_CLK(a_one_cycle, clock, reset, req_valid && req_ready |=> rsp_valid, "accepted word gave no result")

   // command byte only comes with a send command action
   `ASSERT_NEVER(a_cbyte, clock, reset, rsp_valid && rsp_action != ACT_SEND && rsp_command_byte != 8'd0, "command byte without send")

   // no direction bit on send or reject
   `ASSERT_NEVER(a_dir, clock, reset, rsp_valid && rsp_direction && (rsp_action == ACT_SEND || rsp_action == ACT_REJECT), "direction on send or reject")

   // family discrepancy lies within the family byte
   `ASSERT_NEVER(a_family, clock, reset, rsp_valid && rsp_family_discrepancy > 4'd8, "family discrepancy out of range")

endmodule

bind onewire_rom_search_top owrs_checker u_owrs_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_action             (rsp_action),
   .rsp_direction          (rsp_direction),
   .rsp_command_byte       (rsp_command_byte),
   .rsp_family_discrepancy (rsp_family_discrepancy)
);

// ----- bench/onewire_rom_search_top_tb.sv -----
// self-checking testbench of the 1-wire rom search engine, driven through its req/rsp channels
module onewire_rom_search_top_tb
   import owrs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no word moving on either channel before the run is called hung
   localparam int STALL_LIMIT    = 2000;
   // the one long receiver hold-off, long enough to back the engine up into req
   localparam int SQUEEZE_CYCLES = 80;
   // settle time after the last word; the engine answers in the cycle after it takes a word
   localparam int DRAIN_CYCLES   = 8;
   // request words per random phase, rounded up to the end of a search pass
   localparam int PHASE_WORDS    = 100;
   // passes tried on one simulated bus before a new set of devices is wired up
   localparam int MAX_PASSES     = 6;

   // one request word as it goes over the req channel
   typedef struct packed {
      cmd_type cmd;
      logic    presence;
      logic    id_bit;
      logic    complement_bit;
   } req_item_type;

   // one result word as it comes back on the rsp channel
   typedef struct packed {
      action_type  action;
      logic        direction;
      logic [7:0]  command_byte;
      logic [63:0] rom_id;
      logic [3:0]  family_discrepancy;
      logic        last_device;
   } rsp_word_type;

   // everything the engine remembers between words
   typedef struct packed {
      bit [63:0] rom;         // rom id as built so far
      bit [6:0]  last_disc;   // last discrepancy of the previous pass
      bit [3:0]  family;      // last zero choice inside the family byte
      bit        last_dev;    // previous pass found the last device
      bit [6:0]  bit_pos;     // next bit of the pass, 1 based
      bit [6:0]  pass_zero;   // last zero choice seen in this pass
      bit        active;      // a pass is running
   } search_state_type;

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd            = 2'd0;
   logic        req_presence       = 1'b0;
   logic        req_id_bit         = 1'b0;
   logic        req_complement_bit = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [2:0]  rsp_action;
   logic        rsp_direction;
   logic [7:0]  rsp_command_byte;
   logic [63:0] rsp_rom_id;
   logic [3:0]  rsp_family_discrepancy;
   logic        rsp_last_device;
   logic        csr_wr_en          = 1'b0;
   logic [7:0]  csr_wr_data        = 8'd0;

   // words waiting to be offered, and results owed by the engine, oldest first
   req_item_type     pending_items[$];
   rsp_word_type     expected_words[$];
   req_item_type     on_wire;

   // engine image used for checking, and a second image that runs ahead while
   // words are planned so the simulated bus can answer the path being taken
   search_state_type engine;
   search_state_type planner;
   bit [7:0]         search_cmd_shadow;

   // devices hanging on the simulated bus, rom ids lsb first
   bit [63:0]     bus_devices[$];

   int            error_count     = 0;
   int            send_gap_pct    = 27;
   int            take_gap_pct    = 27;
   bit            squeeze_pending = 1'b0;
   bit            squeeze_done    = 1'b0;
   int            hold_left       = 0;

   onewire_rom_search_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_cmd                (req_cmd),
      .req_presence           (req_presence),
      .req_id_bit             (req_id_bit),
      .req_complement_bit     (req_complement_bit),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_action             (rsp_action),
      .rsp_direction          (rsp_direction),
      .rsp_command_byte       (rsp_command_byte),
      .rsp_rom_id             (rsp_rom_id),
      .rsp_family_discrepancy (rsp_family_discrepancy),
      .rsp_last_device        (rsp_last_device),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic search_state_type idle_state();
      search_state_type st;
      st = '0;
      st.bit_pos = FIRST_BIT;
      return st;
   endfunction

   function automatic req_item_type make_item(cmd_type c, bit p, bit i, bit k);
      req_item_type it;
      it.cmd            = c;
      it.presence       = p;
      it.id_bit         = i;
      it.complement_bit = k;
      return it;
   endfunction

   // the marks survive between passes; the rom id itself is never cleared
   task automatic clear_marks(inout search_state_type st);
      st.last_disc = '0;
      st.last_dev  = 1'b0;
      st.family    = '0;
   endtask

   // one engine decision: advances the state and gives the result word
   task automatic search_step(inout search_state_type st, input req_item_type it,
                              input bit [7:0] cmd_byte, output rsp_word_type w);
      bit [6:0] pos;
      bit [5:0] idx;
      bit       dir;
      w = '0;
      w.action = ACT_REJECT;
      case (it.cmd)
         CMD_START: begin
            // nobody answered, or the last device is already known
            if (st.last_dev || !it.presence) begin
               clear_marks(st);
               st.active = 1'b0;
               w.action  = ACT_NONE;
            end else begin
               st.active      = 1'b1;
               st.bit_pos     = FIRST_BIT;
               st.pass_zero   = '0;
               w.action       = ACT_SEND;
               w.command_byte = cmd_byte;
            end
         end
         CMD_RESET: begin
            clear_marks(st);
            st.active = 1'b0;
         end
         CMD_BIT: begin
            if (st.active && it.id_bit && it.complement_bit) begin
               // no device left on this path
               clear_marks(st);
               st.active = 1'b0;
               w.action  = ACT_NONE;
            end else if (st.active) begin
               pos = st.bit_pos;
               idx = 6'(pos - 7'd1);
               if (it.id_bit != it.complement_bit) begin
                  dir = it.id_bit;
               end else begin
                  // discrepancy: replay the old path, turn at the old mark
                  if (pos < st.last_disc) dir = st.rom[idx];
                  else dir = (pos == st.last_disc);
                  if (!dir) begin
                     st.pass_zero = pos;
                     if (pos <= FAMILY_BITS) st.family = pos[3:0];
                  end
               end
               st.rom[idx] = dir;
               w.direction = dir;
               if (pos >= LAST_BIT) begin
                  st.active    = 1'b0;
                  st.bit_pos   = FIRST_BIT;
                  st.last_disc = st.pass_zero;
                  if (st.last_disc == '0) st.last_dev = 1'b1;
                  // a zero family byte means the pass went wrong
                  if (st.rom[7:0] == 8'd0) begin
                     clear_marks(st);
                     w.action = ACT_NONE;
                  end else begin
                     w.action = ACT_FOUND;
                  end
               end else begin
                  st.bit_pos = pos + 7'd1;
                  w.action   = ACT_WRITE;
               end
            end
         end
         default: ;  // unused selector is rejected like a stray bit pair
      endcase
      w.rom_id             = st.rom;
      w.family_discrepancy = st.family;
      w.last_device        = st.last_dev;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
   endtask

   // queue a word for the driver and run it through the look-ahead image
   task automatic queue_item(input req_item_type it);
      rsp_word_type ignored;
      search_step(planner, it, search_cmd_shadow, ignored);
      pending_items.push_back(it);
   endtask

   // random rom ids on the bus, then whole search passes answered by them;
   // a few words of noise break into the passes
   task automatic plan_searches(input int budget);
      int           passes;
      int           n;
      bit [63:0]    rom;
      bit [63:0]    below;
      bit [5:0]     idx;
      req_item_type it;
      while (budget > 0) begin
         bus_devices.delete();
         n = $urandom_range(1, 4);
         repeat (n) begin
            rom = {$urandom, $urandom};
            // now and then a device whose family byte reads as zero
            if ($urandom_range(0, 4) == 0) rom[7:0] = 8'h00;
            bus_devices.push_back(rom);
         end
         queue_item(make_item(CMD_RESET, 1'($urandom), 1'($urandom), 1'($urandom)));
         budget--;
         passes = 0;
         do begin
            queue_item(make_item(CMD_START, $urandom_range(0, 11) != 0,
                                 1'($urandom), 1'($urandom)));
            budget--;
            passes++;
            while (planner.active) begin
               if ($urandom_range(0, 99) < 3) begin
                  it = make_item(cmd_type'($urandom_range(0, 3)), 1'($urandom),
                                 1'($urandom), 1'($urandom));
               end else begin
                  // wired-and of every device still on the path taken so far
                  it    = make_item(CMD_BIT, 1'($urandom), 1'b1, 1'b1);
                  idx   = 6'(planner.bit_pos - 7'd1);
                  below = (64'd1 << idx) - 64'd1;
                  foreach (bus_devices[d])
                     if (((bus_devices[d] ^ planner.rom) & below) == 64'd0) begin
                        if (bus_devices[d][idx]) it.complement_bit = 1'b0;
                        else it.id_bit = 1'b0;
                     end
               end
               queue_item(it);
               budget--;
            end
         end while (!planner.last_dev && passes < MAX_PASSES && budget > 0);
         // one more start once everything is found, the search must end at once
         if (planner.last_dev) begin
            queue_item(make_item(CMD_START, 1'b1, 1'b0, 1'b0));
            budget--;
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_words.size() != 0);
   endtask

   // only called with the engine idle and nothing owed
   task automatic write_search_command(input bit [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      search_cmd_shadow = value;
   endtask

   // driver: predicts each word as it is taken, then offers the next one
   always @(posedge clock) begin : driver
      rsp_word_type predicted;
      req_item_type nxt;
      bit           busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid;
         if (req_valid && req_ready) begin
            search_step(engine, on_wire, search_cmd_shadow, predicted);
            expected_words.push_back(predicted);
            busy = 1'b0;
         end
         // a word on offer stays put until taken
         if (!busy) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               nxt                = pending_items.pop_front();
               on_wire            = nxt;
               req_valid          <= 1'b1;
               req_cmd            <= nxt.cmd;
               req_presence       <= nxt.presence;
               req_id_bit         <= nxt.id_bit;
               req_complement_bit <= nxt.complement_bit;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result word against the oldest expectation
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word, action", 64'(rsp_action), '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_action !== want.action)
                  report_mismatch("action", 64'(rsp_action), 64'(want.action));
               if (rsp_direction !== want.direction)
                  report_mismatch("direction", 64'(rsp_direction), 64'(want.direction));
               if (rsp_command_byte !== want.command_byte)
                  report_mismatch("command byte", 64'(rsp_command_byte),
                                  64'(want.command_byte));
               if (rsp_rom_id !== want.rom_id)
                  report_mismatch("rom id", rsp_rom_id, want.rom_id);
               if (rsp_family_discrepancy !== want.family_discrepancy)
                  report_mismatch("family discrepancy", 64'(rsp_family_discrepancy),
                                  64'(want.family_discrepancy));
               if (rsp_last_device !== want.last_device)
                  report_mismatch("last device", 64'(rsp_last_device),
                                  64'(want.last_device));
            end
         end
         // one long hold-off while the sender keeps pushing
         if (squeeze_pending && !squeeze_done) begin
            squeeze_done = 1'b1;
            hold_left    = SQUEEZE_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= take_gap_pct);
         end
      end
   end

   // watchdog: too long without a word moving means the engine is stuck
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int       ph;
      bit [7:0] value;
      engine            = idle_state();
      planner           = idle_state();
      search_cmd_shadow = SEARCH_CMD_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, search command still at its reset value
      queue_item(make_item(CMD_BIT,    1'b0, 1'b1, 1'b0));  // bit pair with no search
      queue_item(make_item(CMD_UNUSED, 1'b0, 1'b0, 1'b0));  // unused selector
      queue_item(make_item(CMD_RESET,  1'b1, 1'b1, 1'b1));
      queue_item(make_item(CMD_START,  1'b0, 1'b0, 1'b0));  // no presence
      queue_item(make_item(CMD_START,  1'b1, 1'b0, 1'b0));
      queue_item(make_item(CMD_BIT,    1'b0, 1'b1, 1'b1));  // both ones, abort
      queue_item(make_item(CMD_START,  1'b1, 1'b1, 1'b1));
      queue_item(make_item(CMD_BIT,    1'b1, 1'b0, 1'b1));  // all devices read 0
      queue_item(make_item(CMD_BIT,    1'b0, 1'b1, 1'b0));  // all devices read 1
      queue_item(make_item(CMD_BIT,    1'b1, 1'b0, 1'b0));  // discrepancy in family byte
      queue_item(make_item(CMD_BIT,    1'b0, 1'b0, 1'b0));
      queue_item(make_item(CMD_START,  1'b1, 1'b0, 1'b1));  // restart mid pass
      queue_item(make_item(CMD_BIT,    1'b1, 1'b1, 1'b0));
      queue_item(make_item(CMD_BIT,    1'b0, 1'b0, 1'b0));
      queue_item(make_item(CMD_RESET,  1'b0, 1'b0, 1'b0));  // drops the pass
      queue_item(make_item(CMD_BIT,    1'b1, 1'b0, 1'b1));  // now rejected
      queue_item(make_item(CMD_UNUSED, 1'b1, 1'b1, 1'b1));

      // random phases, each with its own search command: both extremes
      // and the alarm search byte
      for (ph = 0; ph < 3; ph++) begin
         wait_drained();
         case (ph)
            0:       value = 8'h00;
            1:       value = 8'hFF;
            default: value = 8'hEC;
         endcase
         write_search_command(value);
         @(negedge clock);
         // second phase runs flat out on both sides
         send_gap_pct    = (ph == 1) ? 0 : 27;
         take_gap_pct    = (ph == 1) ? 0 : 27;
         squeeze_pending = (ph == 2);
         plan_searches(PHASE_WORDS);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch("words never delivered, count", 64'(expected_words.size()), '0);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- onewire_rom_search_top.f -----
+incdir+sv
sv/owrs_pkg.sv
sv/onewire_rom_search_top.sv
sv/owrs_checker.sv
bench/onewire_rom_search_top_tb.sv
